### rtl/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

   // input and result field widths
   localparam int VALUE_W    = 64;
   localparam int CHAR_W     = 6;
   localparam int DIGIT_W    = 4;
   localparam int RSP_DATA_W = 8;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);

   // ASCII '0' folded to the 6-bit character field
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // BCD correction threshold and offset for shift-and-add-3
   localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_ADJ_ADD = 4'd3;

   // queue head as seen by the converter
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
   } q_head_type;

endpackage

### rtl/b2da_fifo.sv
`timescale 1ns / 1ps

module b2da_fifo
   import b2da_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [63:0] value
   output q_head_type         head,
   input  logic               pop
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [VALUE_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               do_pop;

   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.value = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_tdata;
      end
   end

endmodule

### rtl/b2da_conv.sv
`timescale 1ns / 1ps

module b2da_conv
   import b2da_pkg::*;
#(
   parameter int MAX_DIGITS = 20
)
(
   input  logic              clock,
   input  logic              reset,
   input  q_head_type        head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CHAR_W-1:0] rsp_char,
   output logic              rsp_last
);

   // digit positions held, limited to 1..20
   localparam int DIGITS = (MAX_DIGITS > 20) ? 20 : ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
   localparam int BCD_W  = DIGITS * DIGIT_W;
   localparam int REM_W  = $clog2(DIGITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BCD_W-1:0]     bcd_adj;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic                 lead_ff, lead_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;
   logic [DIGIT_W-1:0]   top_digit;
   logic                 slot_free;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + DIGIT_ADJ_ADD;
         end else begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];
   assign slot_free = !out_valid_ff || rsp_tready;
   assign pop       = (state_ff == ST_IDLE) && head.valid;

   // sequencer: load, shift-and-add-3 per bit, then digits out from the top
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      rem_in       = rem_ff;
      lead_in      = lead_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               bin_in     = head.value;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_W - 1);
               lead_in    = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
            bin_in     = bin_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               rem_in   = REM_W'(DIGITS);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (lead_ff && top_digit == '0 && rem_ff > REM_W'(1)) begin
               // drop a leading zero
               bcd_in = bcd_ff << DIGIT_W;
               rem_in = rem_ff - 1'b1;
            end else if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ASCII_ZERO | CHAR_W'(top_digit);
               out_last_in  = (rem_ff == REM_W'(1));
               bcd_in       = bcd_ff << DIGIT_W;
               rem_in       = rem_ff - 1'b1;
               lead_in      = 1'b0;
               if (rem_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      rem_ff      <= rem_in;
      lead_ff     <= lead_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_char   = out_char_ff;
   assign rsp_last   = out_last_ff;

endmodule

### rtl/binary_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// Binary to decimal ASCII converter.
// req_ channel: one 64-bit unsigned value per transfer on req_tdata.
// rsp_ channel: one ASCII digit per transfer, most significant first, in
//   rsp_tdata[5:0] (upper bits zero); rsp_tlast marks the least significant
//   digit. Leading zeros are dropped; zero gives the single digit '0'.
//   MAX_DIGITS below 20 keeps only the low MAX_DIGITS decimal digits.
// A two-entry input queue takes values while the converter is busy.
// Per value: load, then shift-and-add-3 over every input bit (one input bit per
//   cycle), then the digit positions from the top, dropped leading zeros
//   included, up to the last digit.
//   The bit-serial converter sets the sustained rate: it takes the next value
//   from the queue only once the last digit of the current one is issued.
// The first digit appears after the shift-and-add-3 pass and after every
//   leading zero position has been dropped.
// Reset (synchronous, active high) empties the queue, aborts any conversion
//   and drops a pending digit.
// When rsp_tready is low the current digit holds in the output register and
//   the next digit waits; the queue keeps taking values until it is full.
module binary_to_decimal_ascii_unit
   import b2da_pkg::*;
#(
   parameter int MAX_DIGITS = 20
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [63:0] value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic                  rsp_tlast    // last_digit
);

   q_head_type        head;
   logic              pop;
   logic [CHAR_W-1:0] rsp_char;

   // front: input queue
   b2da_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .pop        (pop)
   );

   // back: converter and digit output
   b2da_conv #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_conv (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - CHAR_W)'(0), rsp_char};

endmodule

### rtl/b2da_checker.sv
`timescale 1ns / 1ps

module b2da_checker
   import b2da_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [VALUE_W-1:0]    req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // a stalled digit holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp transfer changed");

   // every digit is ASCII '0'..'9' with zero padding
   a_rsp_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:4] == 4'h3 && rsp_tdata[3:0] <= 4'd9)
      else $error("rsp digit out of range");

   // reset drops any pending digit
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // the queue is empty right after reset and takes a value
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req not ready after reset");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
